@@ design/mpr_pkg.sv @@
// ----------------------------------------------------------------------------
// mpr_pkg
// Shared types and constants for the masked pixel repair block.
// ----------------------------------------------------------------------------
`default_nettype none
package mpr_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int DATA_W        = 24;
  localparam int COUNT_W       = 16;
  localparam int PIX_W         = DATA_W + COUNT_W;
  localparam int CFG_W         = 16;
  localparam int WIDTH_W       = 11;
  localparam int HEIGHT_W      = 16;
  localparam int DIV_W         = DATA_W + 16;
  localparam int QUOT_W        = DIV_W + 1;
  localparam int SUM_W         = QUOT_W + 2;
  localparam int VALUE_W       = 32;
  localparam int CODE_W        = 3;

  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CODE_W-1:0] CODE_BORDER = 3'd0;
  localparam logic [CODE_W-1:0] CODE_GOOD   = 3'd1;
  localparam logic [CODE_W-1:0] CODE_XPAIR  = 3'd2;
  localparam logic [CODE_W-1:0] CODE_YPAIR  = 3'd3;
  localparam logic [CODE_W-1:0] CODE_BOTH   = 3'd4;

  typedef struct packed {
    logic [COUNT_W-1:0]       cnt;
    logic signed [DATA_W-1:0] data;
  } pix_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_RD4,
    ST_UP,
    ST_EVAL,
    ST_DLOAD,
    ST_DSTEP,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

@@ design/mpr_ram.sv @@
// ----------------------------------------------------------------------------
// mpr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module mpr_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ design/mpr_div.sv @@
// ----------------------------------------------------------------------------
// mpr_div
// Bit-serial signed divider: (data * 65536) / count, truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none
module mpr_div
  import mpr_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic signed [DATA_W-1:0]  data,
  input  wire logic [COUNT_W-1:0]        divisor,
  output logic                           busy,
  output logic                           done,
  output logic signed [QUOT_W-1:0]       quot
);

  localparam int STEP_W = $clog2(DIV_W);

  logic               busy_r, done_r, neg_r;
  logic [STEP_W-1:0]  step_r;
  logic [DIV_W-1:0]   n_r, q_r;
  logic [COUNT_W-1:0] rem_r, div_r;

  logic [DATA_W:0]    mag;
  logic [COUNT_W:0]   rem2;
  logic               ge;

  always_comb begin
    mag  = data[DATA_W-1] ? -{data[DATA_W-1], data} : {1'b0, data};
    rem2 = {rem_r, n_r[DIV_W-1]};
    ge   = rem2 >= {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        step_r <= '0;
        n_r    <= {mag[DATA_W-1:0], 16'b0};
        q_r    <= '0;
        rem_r  <= '0;
        div_r  <= divisor;
        neg_r  <= data[DATA_W-1];
      end else if (busy_r) begin
        n_r   <= {n_r[DIV_W-2:0], 1'b0};
        q_r   <= {q_r[DIV_W-2:0], ge};
        rem_r <= ge ? COUNT_W'(rem2 - {1'b0, div_r}) : rem2[COUNT_W-1:0];
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

endmodule
`default_nettype wire

@@ design/masked_pixel_repair.sv @@
// A repaired pixel runs one serial divide per term (2 or 4).
// A new request is taken only in idle: a pixel first waits out four line-store reads and
//   the write-back, then past the first row any divides and the output handshake; an ignored flush stays idle.
// Output lags one row; the first row gives no results, a drain row emits the last.
// Reset: synchronous, active low; line stores are not cleared.
// ----------------------------------------------------------------------------
// masked_pixel_repair
// Repairs zero-count pixels from a 3x3 cross using a two-row line store.
// ----------------------------------------------------------------------------
`default_nettype none
module masked_pixel_repair
  import mpr_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [DATA_W-1:0]  in_pixel_data,
  input  wire logic [COUNT_W-1:0]        in_pixel_count,
  input  wire logic                      in_flush,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [VALUE_W-1:0]      out_value,
  output logic [COUNT_W-1:0]             out_count,
  output logic [CODE_W-1:0]              out_repair_code,
  output logic                           out_frame_last,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [CFG_W-1:0]          cfg_data
);

  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int AW    = $clog2(2 * MAX_WIDTH);
  localparam int RW    = HEIGHT_W + 1;

  state_t state_r, state_nxt;

  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [CW-1:0]       col_r, col_nxt, c_r;
  logic [HEIGHT_W-1:0] row_r, row_nxt, r_r;
  pix_t                cur_r, left_r, center_r, right_r, up_r;
  logic [3:0]          mask_r, mask_nxt;
  logic                both_r, both_nxt;
  logic signed [SUM_W-1:0] acc_r, acc_nxt;
  logic signed [VALUE_W-1:0] res_value_r, res_value_nxt;
  logic [COUNT_W-1:0]  res_count_r, res_count_nxt;
  logic [CODE_W-1:0]   res_code_r, res_code_nxt;
  logic                res_last_r, res_last_nxt;
  logic                out_valid_r;

  logic [CW-1:0]       w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [CW-1:0]       cn;
  logic [RW-1:0]       rn1, rnext;
  logic [HEIGHT_W-1:0] rn;
  logic                drain, accept, ignore;

  logic                ram_we;
  logic [AW-1:0]       ram_raddr, ram_waddr, base_cur, base_prev;
  logic [PIX_W-1:0]    ram_rdata;

  logic                div_start, div_busy, div_done;
  pix_t                div_pix;
  logic signed [QUOT_W-1:0] div_quot;

  logic [HEIGHT_W-1:0] y;
  logic                border, px, py;
  logic signed [SUM_W-1:0] rnd, shd;

  always_comb begin
    if (32'(width_r) < 3) w_eff = CW'(3);
    else if (32'(width_r) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(width_r);
    h_eff = (height_r < HEIGHT_W'(3)) ? HEIGHT_W'(3) : height_r;

    if (col_r >= w_eff) begin
      cn  = '0;
      rn1 = RW'(row_r) + RW'(1);
    end else begin
      cn  = col_r;
      rn1 = RW'(row_r);
    end
    rn     = (rn1 > RW'(h_eff)) ? '0 : rn1[HEIGHT_W-1:0];
    drain  = rn == h_eff;
    accept = in_valid && !in_stall;
    ignore = !drain && in_flush;

    if (cn + CW'(1) >= w_eff) begin
      rnext = RW'(rn) + RW'(1);
      if (rnext > RW'(h_eff)) rnext = '0;
    end else begin
      rnext = RW'(rn);
    end

    base_cur  = r_r[0] ? AW'(MAX_WIDTH) : '0;
    base_prev = r_r[0] ? '0 : AW'(MAX_WIDTH);

    y      = r_r - HEIGHT_W'(1);
    border = (y == '0) || (y == h_eff - HEIGHT_W'(1)) || (c_r == '0)
             || (c_r == w_eff - CW'(1));
    px     = (left_r.cnt != '0) && (right_r.cnt != '0);
    py     = (up_r.cnt != '0) && (cur_r.cnt != '0);

    rnd = acc_r + (both_r ? SUM_W'(512) : SUM_W'(256));
    shd = both_r ? (rnd >>> 10) : (rnd >>> 9);

    div_pix = left_r;
    if (mask_r[0]) div_pix = left_r;
    else if (mask_r[1]) div_pix = right_r;
    else if (mask_r[2]) div_pix = up_r;
    else div_pix = cur_r;
  end

  always_comb begin
    state_nxt     = state_r;
    in_stall      = 1'b1;
    col_nxt       = col_r;
    row_nxt       = row_r;
    ram_we        = 1'b0;
    ram_waddr     = base_cur + AW'(c_r);
    ram_raddr     = base_prev + AW'(c_r);
    div_start     = 1'b0;
    mask_nxt      = mask_r;
    both_nxt      = both_r;
    acc_nxt       = acc_r;
    res_value_nxt = res_value_r;
    res_count_nxt = res_count_r;
    res_code_nxt  = res_code_r;
    res_last_nxt  = res_last_r;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (accept) begin
          col_nxt = cn;
          row_nxt = rn;
          if (!ignore) begin
            col_nxt   = (cn + CW'(1) >= w_eff) ? '0 : cn + CW'(1);
            row_nxt   = rnext[HEIGHT_W-1:0];
            state_nxt = ST_RD1;
          end
        end
      end
      ST_RD1: begin
        ram_raddr = base_prev + AW'(c_r) - AW'(1);
        state_nxt = ST_RD2;
      end
      ST_RD2: begin
        ram_raddr = base_prev + AW'(c_r);
        state_nxt = ST_RD3;
      end
      ST_RD3: begin
        ram_raddr = base_prev + AW'(c_r) + AW'(1);
        state_nxt = ST_RD4;
      end
      ST_RD4: begin
        ram_raddr = base_cur + AW'(c_r);
        state_nxt = ST_UP;
      end
      ST_UP: begin
        ram_we    = 1'b1;
        state_nxt = (r_r == '0) ? ST_IDLE : ST_EVAL;
      end
      ST_EVAL: begin
        res_value_nxt = {center_r.data, 8'b0};
        res_count_nxt = center_r.cnt;
        res_last_nxt  = (y == h_eff - HEIGHT_W'(1)) && (c_r == w_eff - CW'(1));
        res_code_nxt  = CODE_BORDER;
        state_nxt     = ST_OUT;
        if (!border) begin
          if (center_r.cnt != '0) begin
            res_code_nxt = CODE_GOOD;
          end else if (px || py) begin
            mask_nxt  = {py, py, px, px};
            both_nxt  = px && py;
            acc_nxt   = '0;
            res_count_nxt = COUNT_W'(1);
            res_code_nxt  = (px && py) ? CODE_BOTH : (px ? CODE_XPAIR : CODE_YPAIR);
            state_nxt = ST_DLOAD;
          end
        end
      end
      ST_DLOAD: begin
        if (mask_r == '0) begin
          if (shd > SUM_W'(32'sh7FFFFFFF)) res_value_nxt = 32'sh7FFFFFFF;
          else if (shd < -SUM_W'(33'sh080000000)) res_value_nxt = 32'sh80000000;
          else res_value_nxt = VALUE_W'(shd);
          state_nxt = ST_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DSTEP;
        end
      end
      ST_DSTEP: begin
        if (div_done) begin
          acc_nxt = acc_r + SUM_W'(div_quot);
          if (mask_r[0]) mask_nxt[0] = 1'b0;
          else if (mask_r[1]) mask_nxt[1] = 1'b0;
          else if (mask_r[2]) mask_nxt[2] = 1'b0;
          else mask_nxt[3] = 1'b0;
          state_nxt = ST_DLOAD;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      width_r     <= WIDTH_W'(1024);
      height_r    <= HEIGHT_W'(1024);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:  width_r  <= cfg_data[WIDTH_W-1:0];
          CFG_IMAGE_HEIGHT: height_r <= cfg_data[HEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (state_r == ST_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mask_r      <= mask_nxt;
    both_r      <= both_nxt;
    acc_r       <= acc_nxt;
    res_value_r <= res_value_nxt;
    res_count_r <= res_count_nxt;
    res_code_r  <= res_code_nxt;
    res_last_r  <= res_last_nxt;
    if (accept && !ignore) begin
      c_r          <= cn;
      r_r          <= rn;
      cur_r.data   <= drain ? '0 : in_pixel_data;
      cur_r.cnt    <= drain ? '0 : in_pixel_count;
    end
    if (state_r == ST_RD2) left_r   <= ram_rdata;
    if (state_r == ST_RD3) center_r <= ram_rdata;
    if (state_r == ST_RD4) right_r  <= ram_rdata;
    if (state_r == ST_UP)  up_r     <= ram_rdata;
    if (state_r == ST_OUT && (!out_valid_r || !out_stall)) begin
      out_value       <= res_value_r;
      out_count       <= res_count_r;
      out_repair_code <= res_code_r;
      out_frame_last  <= res_last_r;
    end
  end

  assign out_valid = out_valid_r;

  mpr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (2 * MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cur_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mpr_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .data    (div_pix.data),
    .divisor (div_pix.cnt),
    .busy    (div_busy),
    .done    (div_done),
    .quot    (div_quot)
  );

`ifndef SYNTHESIS
  a_repaired_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_repair_code == CODE_XPAIR || out_repair_code == CODE_YPAIR
    || out_repair_code == CODE_BOTH) |-> out_count == COUNT_W'(1))
    else $error("repaired pixel without unit count");
  a_good_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_repair_code == CODE_GOOD |-> out_count != '0)
    else $error("good pixel with zero count");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DSTEP)
    else $error("divider result outside the divide step");
`endif

endmodule
`default_nettype wire

@@ sim/masked_pixel_repair_test.sv @@
// ----------------------------------------------------------------------------
// masked_pixel_repair_test
// Self-checking bench for the masked pixel repair block. It opens with a
// table of directed pixels on a 4x4 frame, then runs random frames of many
// shapes with random repair patterns. A behavioral predictor checks all
// results the table leaves open, and the bench throttles both channels at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module masked_pixel_repair_test;
  import mpr_pkg::*;

  localparam int STORE_HALF = 1024;
  localparam int WDOG_LIMIT = 40000;
  localparam int DRAIN_WAIT = 400;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [COUNT_W-1:0]        count;
    logic [CODE_W-1:0]         code;
    logic                      last;
  } px_result_t;

  typedef struct {
    logic signed [DATA_W-1:0] data;
    logic [COUNT_W-1:0]       count;
    logic                     flush;
    bit                       typed;
    px_result_t               res;
  } stim_row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, in_flush;
  logic signed [DATA_W-1:0] in_pixel_data;
  logic [COUNT_W-1:0] in_pixel_count;
  logic out_valid, out_stall, out_frame_last;
  logic signed [VALUE_W-1:0] out_value;
  logic [COUNT_W-1:0] out_count;
  logic [CODE_W-1:0] out_repair_code;
  logic cfg_we, cfg_index;
  logic [CFG_W-1:0] cfg_data;

  masked_pixel_repair dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pixel_data(in_pixel_data), .in_pixel_count(in_pixel_count), .in_flush(in_flush),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_value(out_value), .out_count(out_count),
    .out_repair_code(out_repair_code), .out_frame_last(out_frame_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // predictor state
  logic signed [DATA_W-1:0] line_data [0:2*STORE_HALF-1];
  logic [COUNT_W-1:0]       line_cnt  [0:2*STORE_HALF-1];
  int unsigned col_pos, row_pos, width_reg, height_reg;

  px_result_t pending_px[$];
  int errors, idle_pct, stall_pct, idle_cycles, rand_items;

  function automatic longint norm_term(logic signed [DATA_W-1:0] d, logic [COUNT_W-1:0] c);
    longint num, den;
    num = longint'(d) * 65536;
    den = longint'({48'd0, c});
    return num / den;
  endfunction

  task automatic repair_model(input logic signed [DATA_W-1:0] d_in,
                              input logic [COUNT_W-1:0] c_in, input logic f_in,
                              output bit emit, output px_result_t res);
    int unsigned w, h, r, c, cur, prv, y;
    logic signed [DATA_W-1:0] d, ud, md, ld, rd;
    logic [COUNT_W-1:0] cnt, uc, mc, lc, rc;
    longint s, val;
    bit px, py, border;
    emit = 0;
    res = '{0, 0, CODE_BORDER, 0};
    w = width_reg < 3 ? 3 : (width_reg > STORE_HALF ? STORE_HALF : width_reg);
    h = height_reg < 3 ? 3 : height_reg;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos > h) row_pos = 0;
    r = row_pos;
    c = col_pos;
    if (r != h && f_in) return;
    d = (r == h) ? '0 : d_in;
    cnt = (r == h) ? '0 : c_in;
    cur = (r & 1) * STORE_HALF;
    prv = ((r + 1) & 1) * STORE_HALF;
    ud = line_data[cur+c];
    uc = line_cnt[cur+c];
    md = line_data[prv+c];
    mc = line_cnt[prv+c];
    ld = c > 0 ? line_data[prv+c-1] : '0;
    lc = c > 0 ? line_cnt[prv+c-1] : '0;
    rd = c + 1 < w ? line_data[prv+c+1] : '0;
    rc = c + 1 < w ? line_cnt[prv+c+1] : '0;
    line_data[cur+c] = d;
    line_cnt[cur+c] = cnt;
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos > h) row_pos = 0;
    end
    if (r == 0) return;
    emit = 1;
    y = r - 1;
    val = longint'(md) * 256;
    res.count = mc;
    border = (y == 0) || (y == h - 1) || (c == 0) || (c == w - 1);
    if (!border) begin
      if (mc != 0) begin
        res.code = CODE_GOOD;
      end else begin
        px = lc != 0 && rc != 0;
        py = uc != 0 && cnt != 0;
        if (px || py) begin
          s = 0;
          if (px) s += norm_term(ld, lc) + norm_term(rd, rc);
          if (py) s += norm_term(ud, uc) + norm_term(d, cnt);
          if (px && py) val = (s + 512) >>> 10;
          else val = (s + 256) >>> 9;
          if (val > 64'sd2147483647) val = 64'sd2147483647;
          if (val < -64'sd2147483648) val = -64'sd2147483648;
          res.count = COUNT_W'(1);
          res.code = (px && py) ? CODE_BOTH : (px ? CODE_XPAIR : CODE_YPAIR);
        end
      end
    end
    res.value = val[31:0];
    res.last = (y == h - 1) && (c == w - 1);
  endtask

  task automatic send_px(input logic signed [DATA_W-1:0] d, input logic [COUNT_W-1:0] c,
                         input logic f, input bit typed, input px_result_t typed_res);
    bit emit;
    px_result_t res;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_data <= d;
    in_pixel_count <= c;
    in_flush <= f;
    do @(posedge clk); while (in_stall);
    repair_model(d, c, f, emit, res);
    if (emit) pending_px.push_back(typed ? typed_res : res);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) width_reg = val[WIDTH_W-1:0];
    else height_reg = val;
  endtask

  task automatic settle();
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic send_random(input bit in_drain);
    logic signed [DATA_W-1:0] d;
    logic [COUNT_W-1:0] c;
    logic f;
    int k;
    k = $urandom_range(99);
    if (k < 40) c = 0;
    else if (k < 50) c = 16'hFFFF;
    else if (k < 60) c = 1;
    else c = COUNT_W'($urandom);
    k = $urandom_range(99);
    if (k < 5) d = 24'sh7FFFFF;
    else if (k < 10) d = 24'sh800000;
    else if (k < 30) d = DATA_W'($urandom_range(255) - 128);
    else d = DATA_W'($urandom);
    f = in_drain ? 1'($urandom_range(1)) : ($urandom_range(99) < 3);
    if (!f || in_drain) rand_items++;
    send_px(d, c, f, 0, '{0, 0, CODE_BORDER, 0});
  endtask

  function automatic bit in_drain_row();
    int unsigned h;
    h = height_reg < 3 ? 3 : height_reg;
    return row_pos == h || (row_pos == h - 1 && col_pos >= (width_reg < 3 ? 3 :
      (width_reg > STORE_HALF ? STORE_HALF : width_reg)));
  endfunction

  task automatic run_frame(input bit pause_mid);
    int n;
    n = 0;
    do begin
      send_random(in_drain_row());
      n++;
      if (pause_mid && n == 20) wait_drained();
    end while (!(row_pos == 0 && col_pos == 0));
  endtask

  task automatic set_mode(input int m);
    case (m % 4)
      0: begin idle_pct = 0; stall_pct = 0; end
      1: begin idle_pct = 85; stall_pct = 0; end
      2: begin idle_pct = 0; stall_pct = 85; end
      default: begin idle_pct = 18; stall_pct = 18; end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    px_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_px.size() == 0) begin
        $display("%0t unexpected result value %h count %h code %0d", $time,
                 out_value, out_count, out_repair_code);
        errors++;
      end else begin
        e = pending_px.pop_front();
        if (out_value !== e.value || out_count !== e.count ||
            out_repair_code !== e.code || out_frame_last !== e.last) begin
          $display("%0t mismatch exp %h/%h/%0d/%0d got %h/%h/%0d/%0d", $time,
                   e.value, e.count, e.code, e.last,
                   out_value, out_count, out_repair_code, out_frame_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  stim_row_t dir_tab [22];

  initial begin
    int m;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pixel_data = '0;
    in_pixel_count = '0;
    in_flush = 1'b0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_IMAGE_WIDTH;
    cfg_data = '0;
    errors = 0;
    idle_cycles = 0;
    rand_items = 0;
    col_pos = 0;
    row_pos = 0;
    width_reg = 1024;
    height_reg = 1024;
    for (int i = 0; i < 2 * STORE_HALF; i++) begin
      line_data[i] = '0;
      line_cnt[i] = '0;
    end
    dir_tab = '{
      '{24'sd100, 16'd1, 1'b0, 0, '{0, 0, CODE_BORDER, 0}},
      '{24'sh7FFFFF, 16'hFFFF, 1'b0, 0, '{0, 0, CODE_BORDER, 0}},
      '{24'sh800000, 16'd1, 1'b0, 0, '{0, 0, CODE_BORDER, 0}},
      '{24'sd5, 16'd2, 1'b0, 0, '{0, 0, CODE_BORDER, 0}},
      '{24'sd7, 16'd3, 1'b0, 1, '{32'sd25600, 16'd1, CODE_BORDER, 0}},
      '{24'sd0, 16'd0, 1'b0, 1, '{32'sh7FFFFF00, 16'hFFFF, CODE_BORDER, 0}},
      '{24'sd123, 16'd9, 1'b1, 0, '{0, 0, CODE_BORDER, 0}},
      '{-24'sd9, 16'd4, 1'b0, 1, '{32'sh80000000, 16'd1, CODE_BORDER, 0}},
      '{24'sd3, 16'd1, 1'b0, 1, '{32'sd1280, 16'd2, CODE_BORDER, 0}},
      '{24'sd0, 16'd0, 1'b0, 0, '{0, 0, CODE_BORDER, 0}},
      '{24'sd0, 16'd0, 1'b0, 0, '{0, 0, CODE_BORDER, 0}},
      '{24'sd0, 16'd0, 1'b0, 0, '{0, 0, CODE_BORDER, 0}},
      '{24'sd1, 16'hFFFF, 1'b0, 0, '{0, 0, CODE_BORDER, 0}},
      '{24'sd11, 16'd5, 1'b0, 0, '{0, 0, CODE_BORDER, 0}},
      '{24'sh800000, 16'hFFFF, 1'b0, 0, '{0, 0, CODE_BORDER, 0}},
      '{24'sd55, 16'd0, 1'b1, 0, '{0, 0, CODE_BORDER, 0}},
      '{24'sh7FFFFF, 16'd1, 1'b0, 0, '{0, 0, CODE_BORDER, 0}},
      '{24'sd0, 16'd0, 1'b0, 0, '{0, 0, CODE_BORDER, 0}},
      '{24'sd0, 16'd0, 1'b1, 0, '{0, 0, CODE_BORDER, 0}},
      '{24'sd77, 16'd5, 1'b0, 0, '{0, 0, CODE_BORDER, 0}},
      '{24'sd0, 16'd0, 1'b1, 0, '{0, 0, CODE_BORDER, 0}},
      '{24'sd0, 16'd0, 1'b1, 1, '{32'sd0, 16'd0, CODE_BORDER, 1}}
    };
    set_mode(0);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(CFG_IMAGE_WIDTH, 16'd4);
    write_reg(CFG_IMAGE_HEIGHT, 16'd4);
    foreach (dir_tab[i])
      send_px(dir_tab[i].data, dir_tab[i].count, dir_tab[i].flush,
              dir_tab[i].typed, dir_tab[i].res);

    // widest row, out-of-range width and height clamp, then narrow rows
    settle();
    write_reg(CFG_IMAGE_WIDTH, 16'd1024);
    write_reg(CFG_IMAGE_WIDTH, 16'hF7FF);
    write_reg(CFG_IMAGE_HEIGHT, 16'd0);
    do send_random(0); while (row_pos == 0);
    settle();
    write_reg(CFG_IMAGE_WIDTH, 16'd4);
    run_frame(0);

    // tallest frame, cut short by a height change
    settle();
    write_reg(CFG_IMAGE_WIDTH, 16'd5);
    write_reg(CFG_IMAGE_HEIGHT, 16'hFFFF);
    set_mode(3);
    repeat (60) send_random(0);
    settle();
    write_reg(CFG_IMAGE_HEIGHT, 16'd4);
    run_frame(0);

    m = 0;
    rand_items = 0;
    while (rand_items < 760) begin
      settle();
      set_mode(m);
      if ($urandom_range(9) == 0)
        write_reg(CFG_IMAGE_WIDTH, {5'($urandom), 11'($urandom_range(2))});
      else
        write_reg(CFG_IMAGE_WIDTH, {5'($urandom), 11'($urandom_range(12, 3))});
      if ($urandom_range(9) == 0) write_reg(CFG_IMAGE_HEIGHT, 16'($urandom_range(2)));
      else write_reg(CFG_IMAGE_HEIGHT, 16'($urandom_range(8, 3)));
      run_frame(m == 5);
      m++;
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
design/mpr_pkg.sv
design/mpr_ram.sv
design/mpr_div.sv
design/masked_pixel_repair.sv
sim/masked_pixel_repair_test.sv
